// File: rtl/oda_pkg.sv
// Package with the types, codes and helper functions of the object dictionary block.
`default_nettype none
package oda_pkg;

  localparam int SLOT_W = 6;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_SIZE  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_TOOLONG  = 2'd3;

  localparam logic [2:0] TYPE_I8   = 3'd0;
  localparam logic [2:0] TYPE_U8   = 3'd1;
  localparam logic [2:0] TYPE_I16  = 3'd2;
  localparam logic [2:0] TYPE_U16  = 3'd3;
  localparam logic [2:0] TYPE_I32  = 3'd4;
  localparam logic [2:0] TYPE_U32  = 3'd5;
  localparam logic [2:0] TYPE_F32  = 3'd6;
  localparam logic [2:0] TYPE_BOOL = 3'd7;

  typedef struct packed {
    logic [23:0] key;
    logic [2:0]  typ;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] value;
  } entry_t;

  function automatic logic [2:0] type_bytes(input logic [2:0] t);
    case (t)
      TYPE_I16, TYPE_U16:           return 3'd2;
      TYPE_I32, TYPE_U32, TYPE_F32: return 3'd4;
      default:                      return 3'd1;
    endcase
  endfunction

  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    case (n)
      3'd0:    return 32'h0000_0000;
      3'd1:    return 32'h0000_00FF;
      3'd2:    return 32'h0000_FFFF;
      3'd3:    return 32'h00FF_FFFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // Maps a value of the given type to an unsigned word that orders like the value.
  function automatic logic [31:0] order_key(input logic [2:0] t, input logic [31:0] x);
    logic [31:0] b;
    logic [31:0] m;
    if (t == TYPE_F32) begin
      b = (x == 32'h8000_0000) ? 32'd0 : x;
      return b[31] ? ~b : (b | 32'h8000_0000);
    end
    m = byte_mask(type_bytes(t));
    b = x & m;
    if (!t[0]) begin
      b = b ^ ((m >> 1) + 32'd1);
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/oda_if.sv
// Channel interfaces for request and response words of the object dictionary block.
`default_nettype none
interface oda_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] key_index;
  logic [7:0]  key_subindex;
  logic [5:0]  load_slot;
  logic [2:0]  load_type;
  logic [31:0] load_min;
  logic [31:0] load_max;
  logic [31:0] write_value;
  logic [2:0]  byte_count;

  modport source (output valid, cmd, key_index, key_subindex, load_slot, load_type,
                  load_min, load_max, write_value, byte_count, input ready);
  modport sink (input valid, cmd, key_index, key_subindex, load_slot, load_type,
                load_min, load_max, write_value, byte_count, output ready);
endinterface

interface oda_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [2:0]  length_out;
  logic [1:0]  status;

  modport source (output valid, read_data, length_out, status, input ready);
  modport sink (input valid, read_data, length_out, status, output ready);
endinterface
`default_nettype wire

// File: rtl/oda_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module oda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/oda_cmp.sv
// Shared unsigned magnitude comparator used for both limits of the range check.
`default_nettype none
module oda_cmp (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             ge
);
  assign ge = (a >= b);
endmodule
`default_nettype wire

// File: rtl/object_dictionary_access.sv
// Top level of the object dictionary block: sequencer, slot table and result register.
//
// Requests arrive as words on req, responses leave as words on rsp; a word moves
// when valid and ready are both high. Every request gives exactly one response.
// A load writes one table slot, or answers not found for a slot at or beyond ENTRIES.
// Read, write and size queries scan the slot table through its single read port,
// one slot per cycle, and stop at the lowest valid matching slot; a write with a range
// check then does the two limit compares in the shared comparator and the write-back.
// The block takes one request at a time; req.ready is high only while it is idle.
// A finished response waits in the output register, so the next request is accepted
// while the receiver stalls; it finishes but holds in the result state until rsp is
// free. Reset clears the valid marks of all slots and the control state; the slot
// contents themselves are not cleared.
`default_nettype none
module object_dictionary_access #(
  parameter int ENTRIES = 64
) (
  input  wire logic clk,
  input  wire logic rst,
  oda_req_if.sink   req,
  oda_rsp_if.source rsp
);
  import oda_pkg::*;

  // Load slots are six bits wide, so no slot beyond that span can ever be filled.
  localparam int DEPTH = (ENTRIES < 2 ** SLOT_W) ? ENTRIES : 2 ** SLOT_W;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SCAN, S_EXEC, S_CHK_LO, S_CHK_HI, S_COMMIT, S_RESULT
  } state_t;

  state_t      state;
  logic [1:0]  cmd;
  logic [23:0] key;
  logic [5:0]  slot;
  logic [2:0]  ltype;
  logic [31:0] lmin;
  logic [31:0] lmax;
  logic [31:0] wval;
  logic [2:0]  cnt;

  logic [DEPTH-1:0] valid;
  logic [SW-1:0]    scan_idx;
  logic             pend;
  logic [AW-1:0]    pend_addr;
  logic [AW-1:0]    hit_addr;
  entry_t           ent;

  logic [31:0] res_data;
  logic [2:0]  res_len;
  logic [1:0]  res_st;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t            rd_ent;

  logic        slot_ok;
  logic        issuing;
  logic        match;
  logic [2:0]  sz;
  logic        len_ok;
  logic [31:0] v_key;
  logic [31:0] lo_key;
  logic [31:0] hi_key;
  logic [31:0] cmp_a;
  logic [31:0] cmp_b;
  logic        cmp_ge;
  logic [31:0] wmask;

  assign req.ready = (state == S_IDLE);

  assign slot_ok  = (32'(slot) < ENTRIES);
  assign issuing  = (scan_idx != SW'(DEPTH));
  assign rd_ent   = entry_t'(ram_rdata);
  assign match    = pend && valid[pend_addr] && (rd_ent.key == key);
  assign sz       = type_bytes(ent.typ);
  assign len_ok   = (cnt <= sz);
  assign wmask    = byte_mask(cnt);

  assign v_key  = order_key(ent.typ, wval);
  assign lo_key = order_key(ent.typ, ent.lo);
  assign hi_key = order_key(ent.typ, ent.hi);
  assign cmp_a  = (state == S_CHK_HI) ? hi_key : v_key;
  assign cmp_b  = (state == S_CHK_HI) ? v_key : lo_key;

  oda_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .ge (cmp_ge)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = hit_addr;
    ram_wdata = ent;
    if (state == S_LOAD) begin
      ram_we          = slot_ok;
      ram_waddr       = slot[AW-1:0];
      ram_wdata.key   = key;
      ram_wdata.typ   = ltype;
      ram_wdata.lo    = lmin;
      ram_wdata.hi    = lmax;
      ram_wdata.value = wval & byte_mask(type_bytes(ltype));
    end else if (state == S_COMMIT) begin
      ram_we          = 1'b1;
      ram_wdata.value = (ent.value & ~wmask) | (wval & wmask);
    end
  end

  assign ram_re = (state == S_SCAN) && issuing;

  oda_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      pend      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      // A word leaving while the next one is being loaded keeps valid high.
      if (rsp.valid && rsp.ready && (state != S_RESULT)) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd      <= req.cmd;
            key      <= {req.key_index, req.key_subindex};
            slot     <= req.load_slot;
            ltype    <= req.load_type;
            lmin     <= req.load_min;
            lmax     <= req.load_max;
            wval     <= req.write_value;
            cnt      <= req.byte_count;
            scan_idx <= '0;
            pend     <= 1'b0;
            res_data <= '0;
            res_len  <= '0;
            res_st   <= ST_OK;
            state    <= (req.cmd == CMD_LOAD) ? S_LOAD : S_SCAN;
          end
        end
        S_LOAD: begin
          if (slot_ok) begin
            valid[slot[AW-1:0]] <= 1'b1;
          end else begin
            res_st <= ST_NOTFOUND;
          end
          state <= S_RESULT;
        end
        S_SCAN: begin
          pend      <= issuing && !match;
          pend_addr <= scan_idx[AW-1:0];
          if (issuing) begin
            scan_idx <= scan_idx + SW'(1);
          end
          if (match) begin
            ent      <= rd_ent;
            hit_addr <= pend_addr;
            state    <= S_EXEC;
          end else if (!pend && !issuing) begin
            res_st <= ST_NOTFOUND;
            state  <= S_RESULT;
          end
        end
        S_EXEC: begin
          case (cmd)
            CMD_READ: begin
              res_len  <= (cnt < sz) ? cnt : sz;
              res_data <= ent.value & byte_mask((cnt < sz) ? cnt : sz);
              state    <= S_RESULT;
            end
            CMD_WRITE: begin
              if (ent.typ == TYPE_BOOL) begin
                if (len_ok) begin
                  state <= S_COMMIT;
                end else begin
                  res_st <= ST_TOOLONG;
                  state  <= S_RESULT;
                end
              end else if ((ent.typ == TYPE_F32) &&
                           (is_nan(wval) || is_nan(ent.lo) || is_nan(ent.hi))) begin
                res_st <= ST_RANGE;
                state  <= S_RESULT;
              end else begin
                state <= S_CHK_LO;
              end
            end
            default: begin
              res_len <= sz;
              state   <= S_RESULT;
            end
          endcase
        end
        S_CHK_LO: begin
          if (cmp_ge) begin
            state <= S_CHK_HI;
          end else begin
            res_st <= ST_RANGE;
            state  <= S_RESULT;
          end
        end
        S_CHK_HI: begin
          if (!cmp_ge) begin
            res_st <= ST_RANGE;
            state  <= S_RESULT;
          end else if (!len_ok) begin
            res_st <= ST_TOOLONG;
            state  <= S_RESULT;
          end else begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          res_len <= cnt;
          state   <= S_RESULT;
        end
        S_RESULT: begin
          // Hold the finished word until the output register is free.
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.read_data  <= res_data;
            rsp.length_out <= res_len;
            rsp.status     <= res_st;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: dv/object_dictionary_access_test.sv
// Self-checking testbench for the object dictionary block with a queue-fed driver and monitor.
`default_nettype none
module object_dictionary_access_test;
  import oda_pkg::*;

  localparam int SLOTS = 64;
  localparam int RANDOM_WORDS = 600;
  localparam int QUIET_TAIL = 60;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] idx;
    logic [7:0]  sub;
    logic [5:0]  slot;
    logic [2:0]  typ;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] wval;
    logic [2:0]  cnt;
    bit          hold;
  } req_word_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  len;
    logic [1:0]  st;
  } dict_answer_t;

  typedef struct {
    bit          used;
    logic [23:0] key;
    logic [2:0]  typ;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] val;
  } dict_slot_t;

  logic clk;
  logic rst;

  oda_req_if req_ch ();
  oda_rsp_if rsp_ch ();

  object_dictionary_access #(.ENTRIES(SLOTS)) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  dict_slot_t   dict_copy [SLOTS];
  req_word_t    request_words [$];
  dict_answer_t awaited_responses [$];
  logic [23:0]  key_pool [16];
  logic [31:0]  value_marks [16] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
    32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
    32'hFFFF_FFFF, 32'h0000_0080, 32'h0000_007F, 32'h0000_8000,
    32'h0000_7FFF, 32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_FF80
  };
  int errors = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit calm = 1'b0;
  bit next_valid;
  req_word_t cur;

  function automatic logic [2:0] width_bytes(logic [2:0] t);
    case (t)
      TYPE_I16, TYPE_U16:           return 3'd2;
      TYPE_I32, TYPE_U32, TYPE_F32: return 3'd4;
      default:                      return 3'd1;
    endcase
  endfunction

  function automatic logic [31:0] lane_mask(logic [2:0] n);
    if (n >= 3'd4) return 32'hFFFF_FFFF;
    return (32'd1 << (8 * n)) - 32'd1;
  endfunction

  function automatic bit is_nan_bits(logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  // Turns a value into an unsigned word whose ordering matches the type's ordering.
  function automatic logic [31:0] order_rank(logic [2:0] t, logic [31:0] x);
    logic [31:0] m;
    if (t == TYPE_F32) begin
      if (x == 32'h8000_0000) x = 32'd0;
      return x[31] ? ~x : {1'b1, x[30:0]};
    end
    m = lane_mask(width_bytes(t));
    x = x & m;
    if (!t[0]) x = x ^ ((m >> 1) + 32'd1);
    return x;
  endfunction

  function automatic bit fits_range(logic [2:0] t, logic [31:0] v, logic [31:0] lo,
                                    logic [31:0] hi);
    if (t == TYPE_BOOL) return 1'b1;
    if (t == TYPE_F32 && (is_nan_bits(v) || is_nan_bits(lo) || is_nan_bits(hi)))
      return 1'b0;
    return order_rank(t, v) >= order_rank(t, lo) && order_rank(t, v) <= order_rank(t, hi);
  endfunction

  // Applies one request word to the dictionary copy and returns the response it gives.
  function automatic dict_answer_t dictionary_response(req_word_t w);
    dict_answer_t a;
    int hit;
    logic [23:0] key;
    logic [2:0] sz;
    logic [31:0] m;
    a = '0;
    a.st = ST_OK;
    hit = -1;
    key = {w.idx, w.sub};
    if (w.cmd == CMD_LOAD) begin
      if (int'(w.slot) < SLOTS)
        dict_copy[w.slot] = '{1'b1, key, w.typ, w.lo, w.hi,
                              w.wval & lane_mask(width_bytes(w.typ))};
      else
        a.st = ST_NOTFOUND;
      return a;
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (dict_copy[i].used && dict_copy[i].key == key) hit = i;
    end
    if (hit < 0) begin
      a.st = ST_NOTFOUND;
      return a;
    end
    sz = width_bytes(dict_copy[hit].typ);
    case (w.cmd)
      CMD_READ: begin
        a.len = (w.cnt < sz) ? w.cnt : sz;
        a.data = dict_copy[hit].val & lane_mask(a.len);
      end
      CMD_WRITE: begin
        if (!fits_range(dict_copy[hit].typ, w.wval, dict_copy[hit].lo, dict_copy[hit].hi)) begin
          a.st = ST_RANGE;
        end else if (w.cnt > sz) begin
          a.st = ST_TOOLONG;
        end else begin
          m = lane_mask(w.cnt);
          dict_copy[hit].val = (dict_copy[hit].val & ~m) | (w.wval & m);
          a.len = w.cnt;
        end
      end
      default: a.len = sz;
    endcase
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h, want %h", what, got, want);
  endtask

  task automatic add_item(logic [1:0] c, logic [15:0] idx, logic [7:0] sub, logic [5:0] slot,
                          logic [2:0] typ, logic [31:0] lo, logic [31:0] hi,
                          logic [31:0] v, logic [2:0] cnt);
    request_words.push_back('{c, idx, sub, slot, typ, lo, hi, v, cnt, 1'b0});
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_LOAD;
    req_ch.key_index = '0;
    req_ch.key_subindex = '0;
    req_ch.load_slot = '0;
    req_ch.load_type = TYPE_I8;
    req_ch.load_min = '0;
    req_ch.load_max = '0;
    req_ch.write_value = '0;
    req_ch.byte_count = '0;
    rsp_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
  end

  // Driver: predicts at acceptance and presents the next word from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      next_valid = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        awaited_responses.push_back(dictionary_response(cur));
        next_valid = 1'b0;
      end
      if (!next_valid && request_words.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!calm && request_words.size() > QUIET_TAIL &&
                     $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 3);
        end else if (!(request_words[0].hold && awaited_responses.size() != 0)) begin
          cur = request_words.pop_front();
          req_ch.cmd <= cur.cmd;
          req_ch.key_index <= cur.idx;
          req_ch.key_subindex <= cur.sub;
          req_ch.load_slot <= cur.slot;
          req_ch.load_type <= cur.typ;
          req_ch.load_min <= cur.lo;
          req_ch.load_max <= cur.hi;
          req_ch.write_value <= cur.wval;
          req_ch.byte_count <= cur.cnt;
          next_valid = 1'b1;
        end
      end
      req_ch.valid <= next_valid;
    end
  end

  // Monitor: checks each response word against the oldest prediction.
  always @(posedge clk) begin
    dict_answer_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_responses.size() == 0) begin
          report_mismatch("response with no request", rsp_ch.read_data, 32'd0);
        end else begin
          want = awaited_responses.pop_front();
          if (rsp_ch.read_data !== want.data)
            report_mismatch("read_data", rsp_ch.read_data, want.data);
          if (rsp_ch.length_out !== want.len)
            report_mismatch("length_out", 32'(rsp_ch.length_out), 32'(want.len));
          if (rsp_ch.status !== want.st)
            report_mismatch("status", 32'(rsp_ch.status), 32'(want.st));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!calm && request_words.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    req_word_t w;
    int pick;
    logic [31:0] m;
    for (int i = 0; i < SLOTS; i++) dict_copy[i].used = 1'b0;
    key_pool[0] = 24'h00_0000;
    key_pool[15] = 24'hFF_FFFF;
    for (int i = 1; i < 15; i++) key_pool[i] = 24'($urandom);

    // Directed part: boundaries, shadowed keys, float signs and NaN, and each refusal.
    add_item(CMD_READ, 16'h1000, 8'h01, 0, 0, 0, 0, 0, 3'd4);
    add_item(CMD_LOAD, 16'h0000, 8'h00, 0, TYPE_I8, 32'hFFFF_FF80, 32'h0000_007F,
             32'hFFFF_FF85, 0);
    add_item(CMD_LOAD, 16'hFFFF, 8'hFF, 63, TYPE_U32, 32'h0, 32'hFFFF_FFFF, 32'h89AB_CDEF, 0);
    add_item(CMD_LOAD, 16'h1234, 8'h56, 5, TYPE_F32, 32'hBF80_0000, 32'h3F80_0000, 32'h0, 0);
    add_item(CMD_LOAD, 16'h1234, 8'h56, 9, TYPE_U16, 32'h0, 32'hFFFF, 32'h5555, 0);
    add_item(CMD_LOAD, 16'h2000, 8'h01, 1, TYPE_I16, 32'hFFFF_FF00, 32'h0000_0100,
             32'h1234_0005, 0);
    add_item(CMD_LOAD, 16'h2000, 8'h02, 3, TYPE_BOOL, 32'h0, 32'h0, 32'h1, 0);
    add_item(CMD_LOAD, 16'h2000, 8'h03, 4, TYPE_U8, 32'h10, 32'h20, 32'h15, 0);
    add_item(CMD_LOAD, 16'h2000, 8'h04, 6, TYPE_F32, 32'h0, 32'h7FC0_0001, 32'h0, 0);
    add_item(CMD_READ, 16'h0000, 8'h00, 0, 0, 0, 0, 0, 3'd0);
    add_item(CMD_READ, 16'h0000, 8'h00, 0, 0, 0, 0, 0, 3'd7);
    add_item(CMD_READ, 16'hFFFF, 8'hFF, 0, 0, 0, 0, 0, 3'd3);
    add_item(CMD_SIZE, 16'h1234, 8'h56, 0, 0, 0, 0, 0, 3'd0);
    add_item(CMD_WRITE, 16'h1234, 8'h56, 0, 0, 0, 0, 32'h8000_0000, 3'd4);
    add_item(CMD_WRITE, 16'h1234, 8'h56, 0, 0, 0, 0, 32'h7FC0_0000, 3'd4);
    add_item(CMD_WRITE, 16'h1234, 8'h56, 0, 0, 0, 0, 32'h3F80_0000, 3'd4);
    add_item(CMD_WRITE, 16'h1234, 8'h56, 0, 0, 0, 0, 32'h4000_0000, 3'd4);
    add_item(CMD_WRITE, 16'h2000, 8'h01, 0, 0, 0, 0, 32'hFFFF_FF00, 3'd2);
    add_item(CMD_WRITE, 16'h2000, 8'h01, 0, 0, 0, 0, 32'h0000_FEFF, 3'd2);
    add_item(CMD_WRITE, 16'h2000, 8'h01, 0, 0, 0, 0, 32'h0000_0100, 3'd3);
    add_item(CMD_WRITE, 16'h2000, 8'h01, 0, 0, 0, 0, 32'h0000_0100, 3'd0);
    add_item(CMD_WRITE, 16'h2000, 8'h02, 0, 0, 0, 0, 32'hABCD_EF99, 3'd1);
    add_item(CMD_WRITE, 16'h2000, 8'h03, 0, 0, 0, 0, 32'h21, 3'd1);
    add_item(CMD_WRITE, 16'h2000, 8'h03, 0, 0, 0, 0, 32'h1F, 3'd6);
    add_item(CMD_WRITE, 16'h2000, 8'h04, 0, 0, 0, 0, 32'h0, 3'd4);
    add_item(CMD_WRITE, 16'h3000, 8'h00, 0, 0, 0, 0, 32'h0, 3'd1);
    add_item(CMD_READ, 16'h2000, 8'h01, 0, 0, 0, 0, 0, 3'd4);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w.cmd = 2'($urandom);
      w.idx = 16'($urandom);
      w.sub = 8'($urandom);
      w.slot = 6'($urandom);
      w.typ = 3'($urandom);
      w.lo = $urandom;
      w.hi = $urandom;
      w.wval = $urandom;
      w.cnt = 3'($urandom_range(0, 4));
      w.hold = (n % 150 == 0);
      if ($urandom_range(0, 9) != 0) {w.idx, w.sub} = key_pool[$urandom_range(0, 15)];
      if ($urandom_range(0, 4) == 0) w.cnt = 3'($urandom_range(0, 7));
      // The table is filled more heavily at first so that lookups mostly hit.
      pick = $urandom_range(0, 99);
      if (n < 40) pick = pick / 2;
      if (pick < 22) w.cmd = CMD_LOAD;
      else if (pick < 45) w.cmd = CMD_READ;
      else if (pick < 85) w.cmd = CMD_WRITE;
      else w.cmd = CMD_SIZE;
      if (w.cmd == CMD_LOAD) begin
        m = lane_mask(width_bytes(w.typ));
        case ($urandom_range(0, 3))
          0: begin
            case (w.typ)
              TYPE_I8:  {w.lo, w.hi} = {32'h0000_0080, 32'h0000_007F};
              TYPE_U8:  {w.lo, w.hi} = {32'h0000_0000, 32'h0000_00FF};
              TYPE_I16: {w.lo, w.hi} = {32'h0000_8000, 32'h0000_7FFF};
              TYPE_U16: {w.lo, w.hi} = {32'h0000_0000, 32'h0000_FFFF};
              TYPE_I32: {w.lo, w.hi} = {32'h8000_0000, 32'h7FFF_FFFF};
              TYPE_U32: {w.lo, w.hi} = {32'h0000_0000, 32'hFFFF_FFFF};
              TYPE_F32: {w.lo, w.hi} = {32'hFF80_0000, 32'h7F80_0000};
              default: ;
            endcase
            if (w.typ != TYPE_F32) begin
              w.lo = (w.lo & m) | ($urandom & ~m);
              w.hi = (w.hi & m) | ($urandom & ~m);
            end
          end
          1: begin
            w.lo = w.wval;
            w.hi = w.wval + $urandom_range(0, 40);
          end
          2: if (w.lo > w.hi) {w.lo, w.hi} = {w.hi, w.lo};
          default: ;
        endcase
      end else begin
        case ($urandom_range(0, 5))
          0: w.wval = $urandom_range(0, 40) | ($urandom & 32'hFFFF_0000);
          1, 2: w.wval = value_marks[$urandom_range(0, 15)];
          default: ;
        endcase
      end
      request_words.push_back(w);
    end

    @(posedge clk);
    while (rst || request_words.size() != 0 || req_ch.valid || awaited_responses.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_responses.size() != 0)
      report_mismatch("responses never arrived", 32'd0, 32'(awaited_responses.size()));
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
